// File: sv/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // most result words one input word can cause: lone surrogate plus a 3 byte code point
    localparam int ResMax = 6;
    localparam int CntW   = 3;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_CLOSE   = 3'd1,
        KIND_BAD_ESC = 3'd2,
        KIND_BAD_UNI = 3'd3,
        KIND_UNTERM  = 3'd4
    } kind_t;

    typedef enum logic [5:0] {
        MODE_NORMAL        = 6'b000001,
        MODE_ESC           = 6'b000010,
        MODE_HEX           = 6'b000100,
        MODE_AFTER_HIGH    = 6'b001000,
        MODE_AFTER_HIGH_BS = 6'b010000,
        MODE_LOW_HEX       = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } res_entry_t;

    typedef struct packed {
        logic [CntW-1:0]              count;
        res_entry_t [ResMax-1:0]      ent;
    } res_list_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    localparam logic [7:0]  ChQuote  = 8'h22;
    localparam logic [7:0]  ChBslash = 8'h5C;
    localparam logic [7:0]  ChU      = 8'h75;
    localparam logic [15:0] HighLo   = 16'hD800;
    localparam logic [15:0] HighHi   = 16'hDBFF;
    localparam logic [15:0] LowLo    = 16'hDC00;
    localparam logic [15:0] LowHi    = 16'hDFFF;
    localparam logic [20:0] SuppBase = 21'h10000;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t u;
        u = '0;
        if (cp < 21'h80) begin
            u.len      = 3'd1;
            u.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.len      = 3'd2;
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.len      = 3'd3;
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.len      = 3'd4;
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // {valid, byte} for the single-letter escapes
    function automatic logic [8:0] escape_value(input logic [7:0] c);
        logic [8:0] r;
        r = '0;
        unique case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/jsu_decode.sv
`default_nettype none

module jsu_decode (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_take,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_end,
    output jsu_pkg::res_list_t     res
);
    import jsu_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [11:0] accum_reg, accum_next;
    logic [1:0]  digits_reg, digits_next;
    logic [9:0]  pending_reg, pending_next;

    logic            pre;
    logic            term;
    kind_t           term_kind;
    utf8_t           body;
    utf8_t           pre_utf8;
    logic [4:0]      hx;
    logic            hex_ok;
    logic [8:0]      esc;
    logic [15:0]     word16;
    logic            is_high;
    logic            is_low;
    logic [20:0]     pair_cp;
    logic [CntW-1:0] pl;
    logic [CntW-1:0] rel [ResMax];

    assign hx       = hex_value(in_byte);
    assign hex_ok   = hx[4] && !in_end;
    assign esc      = escape_value(in_byte);
    assign word16   = {accum_reg, hx[3:0]};
    assign is_high  = (word16 >= HighLo) && (word16 <= HighHi);
    assign is_low   = (word16 >= LowLo) && (word16 <= LowHi);
    assign pair_cp  = SuppBase + {1'b0, pending_reg, word16[9:0]};
    assign pre_utf8 = utf8_encode({5'b0, HighLo[15:10], pending_reg});

    always_comb begin
        mode_next    = mode_reg;
        accum_next   = accum_reg;
        digits_next  = digits_reg;
        pending_next = pending_reg;
        pre          = 1'b0;
        term         = 1'b0;
        term_kind    = KIND_DATA;
        body         = '0;

        unique case (mode_reg)
            MODE_NORMAL: begin
                if (in_end) begin
                    term      = 1'b1;
                    term_kind = KIND_UNTERM;
                end else if (in_byte == ChQuote) begin
                    term      = 1'b1;
                    term_kind = KIND_CLOSE;
                end else if (in_byte == ChBslash) begin
                    mode_next = MODE_ESC;
                end else begin
                    body.len      = 3'd1;
                    body.bytes[0] = in_byte;
                end
            end
            MODE_ESC, MODE_AFTER_HIGH_BS: begin
                mode_next = MODE_NORMAL;
                pre       = (mode_reg == MODE_AFTER_HIGH_BS);
                if (in_end) begin
                    term      = 1'b1;
                    term_kind = KIND_UNTERM;
                end else if (in_byte == ChU) begin
                    pre         = 1'b0;
                    mode_next   = (mode_reg == MODE_ESC) ? MODE_HEX : MODE_LOW_HEX;
                    accum_next  = '0;
                    digits_next = '0;
                end else if (esc[8]) begin
                    body.len      = 3'd1;
                    body.bytes[0] = esc[7:0];
                end else begin
                    term      = 1'b1;
                    term_kind = KIND_BAD_ESC;
                end
            end
            MODE_HEX, MODE_LOW_HEX: begin
                if (!hex_ok) begin
                    pre       = (mode_reg == MODE_LOW_HEX);
                    term      = 1'b1;
                    term_kind = KIND_BAD_UNI;
                    mode_next = MODE_NORMAL;
                end else if (digits_reg != 2'd3) begin
                    accum_next  = word16[11:0];
                    digits_next = digits_reg + 2'd1;
                end else if (mode_reg == MODE_LOW_HEX && is_low) begin
                    body      = utf8_encode(pair_cp);
                    mode_next = MODE_NORMAL;
                end else begin
                    // in the low half mode the lone high surrogate goes out first; the new value starts afresh
                    pre = (mode_reg == MODE_LOW_HEX);
                    if (is_high) begin
                        pending_next = word16[9:0];
                        accum_next   = '0;
                        digits_next  = '0;
                        mode_next    = MODE_AFTER_HIGH;
                    end else begin
                        body      = utf8_encode({5'b0, word16});
                        mode_next = MODE_NORMAL;
                    end
                end
            end
            MODE_AFTER_HIGH: begin
                mode_next = MODE_NORMAL;
                pre       = 1'b1;
                if (in_end) begin
                    term      = 1'b1;
                    term_kind = KIND_UNTERM;
                end else if (in_byte == ChBslash) begin
                    pre       = 1'b0;
                    mode_next = MODE_AFTER_HIGH_BS;
                end else if (in_byte == ChQuote) begin
                    term      = 1'b1;
                    term_kind = KIND_CLOSE;
                end else begin
                    body.len      = 3'd1;
                    body.bytes[0] = in_byte;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
            end
        endcase
    end

    // result list: held-back surrogate, then decoded bytes, then a status word
    assign pl = pre ? CntW'(3) : CntW'(0);

    always_comb begin
        res       = '0;
        res.count = pl + body.len + {{(CntW-1){1'b0}}, term};
        for (int i = 0; i < ResMax; i++) begin
            rel[i] = CntW'(i) - pl;
            if (CntW'(i) < pl) begin
                res.ent[i].data = pre_utf8.bytes[i[1:0]];
                res.ent[i].kind = KIND_DATA;
            end else if (rel[i] < body.len) begin
                res.ent[i].data = body.bytes[rel[i][1:0]];
                res.ent[i].kind = KIND_DATA;
            end else if (term && rel[i] == body.len) begin
                res.ent[i].data = 8'h00;
                res.ent[i].kind = term_kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
        end else if (in_take) begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            accum_reg   <= accum_next;
            digits_reg  <= digits_next;
            pending_reg <= pending_next;
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> res.count <= CntW'(ResMax))
        else $error("result list longer than the buffer");

    a_low_hex_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take && mode_reg == MODE_AFTER_HIGH_BS && !in_end && in_byte == ChU
        |=> mode_reg == MODE_LOW_HEX && digits_reg == 2'd0)
        else $error("backslash u after high surrogate did not start low half");

    a_pair_len: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take && mode_reg == MODE_LOW_HEX && digits_reg == 2'd3 && hex_ok && is_low
        |-> res.count == CntW'(4))
        else $error("surrogate pair not encoded as four bytes");

endmodule

`default_nettype wire

// File: sv/jsu_outbuf.sv
`default_nettype none

module jsu_outbuf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire jsu_pkg::res_list_t res,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_data,
    output jsu_pkg::kind_t          m_kind,
    output logic                    m_last
);
    import jsu_pkg::*;

    res_entry_t [ResMax-1:0] ent_reg, ent_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic                    take;
    logic                    load;

    assign m_valid  = (cnt_reg != '0);
    assign m_data   = ent_reg[0].data;
    assign m_kind   = ent_reg[0].kind;
    assign m_last   = (cnt_reg == CntW'(1));
    assign take     = m_valid && m_ready;
    assign in_ready = (cnt_reg == '0) || (m_last && m_ready);
    assign load     = in_valid && in_ready && (res.count != '0);

    always_comb begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (take) begin
            for (int i = 0; i < ResMax - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
            cnt_next = cnt_reg - CntW'(1);
        end
        if (load) begin
            ent_next = res.ent;
            cnt_next = res.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(ResMax))
        else $error("output count out of range");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == '0) || (cnt_reg == CntW'(1) && take))
        else $error("new results loaded over pending words");

endmodule

`default_nettype wire

// File: sv/json_string_unescape_utf8.sv
// latency: the first result word of an input word is offered the cycle after it is accepted
// throughput: one input word per cycle while each causes at most one result word and the receiver takes it
// an input word that causes n results (up to six) holds off further input until its last result is taken
// words that cause no result (backslash, u, leading hex digits) are taken back to back
// reset (aresetn low, synchronous) empties the output buffer and returns to plain byte mode
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input words
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tuser,   // [0] is_end
    // result words
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [2:0]      m_tuser,   // [2:0] kind
    output logic            m_tlast
);
    import jsu_pkg::*;

    res_list_t res;
    kind_t     out_kind;
    logic      in_take;

    // decoder state only moves on an accepted word
    assign in_take = s_tvalid && s_tready;

    // escape and utf-8 decode: mode register plus combinational result list
    jsu_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (in_take),
        .in_byte (s_tdata),
        .in_end  (s_tuser),
        .res     (res)
    );

    // result register that drains the list one word per cycle while the receiver is ready
    jsu_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .res      (res),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata),
        .m_kind   (out_kind),
        .m_last   (m_tlast)
    );

    assign m_tuser = out_kind;

endmodule

`default_nettype wire

// File: tb/sv/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    // generous bound on the whole run, far above the slowest clean run
    localparam int CycleLimit = 200000;

    // one expected result word: decoded byte, kind, end-of-item flag
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_word_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tuser  = 1'b0;    // [0] is_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [2:0] m_tuser;            // [2:0] kind
    logic       m_tlast;

    // idle rates in percent for each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int words_sent     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // decoder state mirrored by the predictor
    mode_t       dec_mode   = MODE_NORMAL;
    logic [15:0] dec_acc    = '0;
    logic [2:0]  dec_digits = '0;
    logic [15:0] dec_high   = '0;

    result_word_t item_words[$];      // results of the word being predicted
    result_word_t expected_words[$];  // results still owed by the block
    result_word_t oldest;

    json_string_unescape_utf8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // back to plain byte mode with nothing held
    task automatic decoder_clear();
        dec_mode   = MODE_NORMAL;
        dec_acc    = '0;
        dec_digits = '0;
        dec_high   = '0;
    endtask

    task automatic put_word(input logic [7:0] d, input kind_t k);
        result_word_t w;
        w = '{data: d, kind: k, last: 1'b0};
        item_words.insert(item_words.size(), w);
    endtask

    // utf-8 bytes of one code point, lead byte first
    task automatic put_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_word(cp[7:0], KIND_DATA);
        end else if (cp < 21'h800) begin
            put_word(8'hC0 | 8'(cp >> 6), KIND_DATA);
            put_word(8'h80 | {2'b00, cp[5:0]}, KIND_DATA);
        end else if (cp < 21'h10000) begin
            put_word(8'hE0 | 8'(cp >> 12), KIND_DATA);
            put_word(8'h80 | {2'b00, cp[11:6]}, KIND_DATA);
            put_word(8'h80 | {2'b00, cp[5:0]}, KIND_DATA);
        end else begin
            put_word(8'hF0 | 8'(cp >> 18), KIND_DATA);
            put_word(8'h80 | {2'b00, cp[17:12]}, KIND_DATA);
            put_word(8'h80 | {2'b00, cp[11:6]}, KIND_DATA);
            put_word(8'h80 | {2'b00, cp[5:0]}, KIND_DATA);
        end
    endtask

    // digit value, or -1 when the byte is no hex digit
    function automatic int hex_digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
        return -1;
    endfunction

    // byte seen in plain mode
    task automatic plain_byte(input logic [7:0] c);
        if (c == ChQuote) begin
            put_word(8'h00, KIND_CLOSE);
            decoder_clear();
        end else if (c == ChBslash) begin
            dec_mode = MODE_ESC;
        end else begin
            put_word(c, KIND_DATA);
        end
    endtask

    // byte right after a backslash
    task automatic escaped_byte(input logic [7:0] c);
        logic [7:0] v;
        logic       known;
        v     = 8'h00;
        known = 1'b1;
        case (c)
            ChQuote:  v = ChQuote;
            ChBslash: v = ChBslash;
            8'h2F:    v = 8'h2F;     // slash
            8'h62:    v = 8'h08;     // b
            8'h66:    v = 8'h0C;     // f
            8'h6E:    v = 8'h0A;     // n
            8'h72:    v = 8'h0D;     // r
            8'h74:    v = 8'h09;     // t
            default:  known = 1'b0;
        endcase
        if (c == ChU) begin
            dec_mode   = MODE_HEX;
            dec_acc    = '0;
            dec_digits = '0;
        end else begin
            if (known) put_word(v, KIND_DATA);
            else put_word(8'h00, KIND_BAD_ESC);
            decoder_clear();
        end
    endtask

    // four digits gathered that do not complete a surrogate pair
    task automatic code_complete(input logic [15:0] v);
        if (v >= HighLo && v <= HighHi) begin
            dec_high   = v;
            dec_acc    = '0;
            dec_digits = '0;
            dec_mode   = MODE_AFTER_HIGH;
        end else begin
            put_code_point(21'(v));
            decoder_clear();
        end
    endtask

    // works out every result one accepted input word causes
    task automatic predict_word(input logic [7:0] c, input logic is_end);
        int          d;
        logic [15:0] held;
        logic [20:0] pair;
        item_words.delete();
        case (dec_mode)
            MODE_NORMAL: begin
                if (is_end) begin
                    put_word(8'h00, KIND_UNTERM);
                    decoder_clear();
                end else begin
                    plain_byte(c);
                end
            end
            MODE_ESC: begin
                if (is_end) begin
                    put_word(8'h00, KIND_UNTERM);
                    decoder_clear();
                end else begin
                    escaped_byte(c);
                end
            end
            MODE_HEX, MODE_LOW_HEX: begin
                d = is_end ? -1 : hex_digit_of(c);
                if (d < 0) begin
                    // a held high surrogate goes out before the error
                    if (dec_mode == MODE_LOW_HEX) put_code_point(21'(dec_high));
                    put_word(8'h00, KIND_BAD_UNI);
                    decoder_clear();
                end else begin
                    dec_acc    = {dec_acc[11:0], 4'(d)};
                    dec_digits = dec_digits + 3'd1;
                    if (dec_digits == 3'd4) begin
                        if (dec_mode == MODE_HEX) begin
                            code_complete(dec_acc);
                        end else if (dec_acc >= LowLo && dec_acc <= LowHi) begin
                            pair = SuppBase + ((21'(dec_high) - 21'(HighLo)) << 10)
                                   + (21'(dec_acc) - 21'(LowLo));
                            put_code_point(pair);
                            decoder_clear();
                        end else begin
                            // not a low half: lone high out, then the new value afresh
                            held = dec_acc;
                            put_code_point(21'(dec_high));
                            code_complete(held);
                        end
                    end
                end
            end
            MODE_AFTER_HIGH: begin
                if (is_end) begin
                    put_code_point(21'(dec_high));
                    put_word(8'h00, KIND_UNTERM);
                    decoder_clear();
                end else if (c == ChBslash) begin
                    dec_mode = MODE_AFTER_HIGH_BS;
                end else begin
                    put_code_point(21'(dec_high));
                    decoder_clear();
                    plain_byte(c);
                end
            end
            MODE_AFTER_HIGH_BS: begin
                if (is_end) begin
                    put_code_point(21'(dec_high));
                    put_word(8'h00, KIND_UNTERM);
                    decoder_clear();
                end else if (c == ChU) begin
                    dec_mode   = MODE_LOW_HEX;
                    dec_acc    = '0;
                    dec_digits = '0;
                end else begin
                    put_code_point(21'(dec_high));
                    decoder_clear();
                    escaped_byte(c);
                end
            end
            default: decoder_clear();
        endcase
        if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
        foreach (item_words[i]) expected_words.insert(expected_words.size(), item_words[i]);
    endtask

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // offers one word, with random idle cycles ahead of it, and waits for the handshake
    task automatic send_word(input logic [7:0] b, input logic is_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= is_end;
        do @(posedge aclk); while (!s_tready);
        // accepted at this edge
        words_sent++;
        predict_word(b, is_end);
    endtask

    // hex digit with random letter case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] escape_letter(input int i);
        case (i)
            0: return ChQuote;
            1: return ChBslash;
            2: return 8'h2F;
            3: return 8'h62;
            4: return 8'h66;
            5: return 8'h6E;
            6: return 8'h72;
            default: return 8'h74;
        endcase
    endfunction

    // any byte that is neither a one-letter escape nor u
    function automatic logic [7:0] bad_letter();
        logic [7:0] b;
        logic       hit;
        do begin
            b   = 8'($urandom_range(0, 255));
            hit = (b == ChU);
            for (int i = 0; i < 8; i++) if (b == escape_letter(i)) hit = 1'b1;
        end while (hit);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_digit_of(b) >= 0);
        return b;
    endfunction

    // backslash, u, then the given number of digits of v, most significant first
    task automatic send_u_digits(input logic [15:0] v, input int n_digits);
        send_word(ChBslash, 1'b0);
        send_word(ChU, 1'b0);
        for (int i = 0; i < n_digits; i++) send_word(hex_char(v[15 - 4 * i -: 4]), 1'b0);
    endtask

    // a broken tail: a non-hex byte or the end of text
    task automatic send_bad_digit();
        if ($urandom_range(0, 3) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
        else send_word(non_hex_byte(), 1'b0);
    endtask

    function automatic logic [15:0] high_half();
        return 16'($urandom_range(32'hD800, 32'hDBFF));
    endfunction

    function automatic logic [15:0] low_half();
        return 16'($urandom_range(32'hDC00, 32'hDFFF));
    endfunction

    // one piece of a string body, mostly well formed
    task automatic send_random_token();
        logic [15:0] v;
        case ($urandom_range(0, 21))
            0, 1, 2, 3, 4, 5: send_word(8'($urandom_range(0, 255)), 1'b0);
            6, 7: begin
                send_word(ChBslash, 1'b0);
                send_word(escape_letter($urandom_range(0, 7)), 1'b0);
            end
            8:  send_u_digits(16'($urandom_range(0, 32'h7F)), 4);
            9:  send_u_digits(16'($urandom_range(32'h80, 32'h7FF)), 4);
            10: begin
                if ($urandom_range(0, 1) != 0) v = 16'($urandom_range(32'h800, 32'hD7FF));
                else v = 16'($urandom_range(32'hE000, 32'hFFFF));
                send_u_digits(v, 4);
            end
            11, 12: begin
                send_u_digits(high_half(), 4);
                send_u_digits(low_half(), 4);
            end
            // lone high, whatever follows decides
            13: send_u_digits(high_half(), 4);
            14: send_u_digits(low_half(), 4);
            // high followed by a \u that is no low half
            15: begin
                send_u_digits(high_half(), 4);
                do v = 16'($urandom_range(0, 32'hFFFF)); while (v >= LowLo && v <= LowHi);
                send_u_digits(v, 4);
            end
            // unknown escape letter or end right after the backslash
            16: begin
                send_word(ChBslash, 1'b0);
                if ($urandom_range(0, 3) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
                else send_word(bad_letter(), 1'b0);
            end
            // short or broken \u
            17: begin
                send_u_digits(16'($urandom_range(0, 32'hFFFF)), $urandom_range(0, 3));
                send_bad_digit();
            end
            18: send_word(8'($urandom_range(0, 255)), 1'b1);
            // high then a one-letter escape, a bad letter or the end
            19: begin
                send_u_digits(high_half(), 4);
                send_word(ChBslash, 1'b0);
                case ($urandom_range(0, 2))
                    0: send_word(escape_letter($urandom_range(0, 7)), 1'b0);
                    1: send_word(bad_letter(), 1'b0);
                    default: send_word(8'($urandom_range(0, 255)), 1'b1);
                endcase
            end
            // high then a broken second \u
            20: begin
                send_u_digits(high_half(), 4);
                send_u_digits(16'($urandom_range(0, 32'hFFFF)), $urandom_range(0, 3));
                send_bad_digit();
            end
            // high then the end of text
            default: begin
                send_u_digits(high_half(), 4);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // byte extremes, close quote, end mark with an ignored byte
    task automatic test_byte_extremes();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(ChQuote, 1'b0);
        send_word(8'hFF, 1'b1);
    endtask

    // unknown letter, bad digit, short \u, end after the backslash
    task automatic test_bad_escapes();
        send_word(ChBslash, 1'b0);
        send_word(8'h71, 1'b0);          // q
        send_u_digits(16'h0000, 0);
        send_word(8'h47, 1'b0);          // G
        send_u_digits(16'h1000, 1);
        send_word(8'h00, 1'b1);
        send_word(ChBslash, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // surrogate pair, upper case high half, lower case low half
    task automatic test_surrogate_pair();
        send_word(ChBslash, 1'b0);
        send_word(ChU, 1'b0);
        send_word(8'h44, 1'b0);          // D
        send_word(8'h38, 1'b0);          // 8
        send_word(8'h33, 1'b0);          // 3
        send_word(8'h44, 1'b0);          // D
        send_word(ChBslash, 1'b0);
        send_word(ChU, 1'b0);
        send_word(8'h64, 1'b0);          // d
        send_word(8'h65, 1'b0);          // e
        send_word(8'h30, 1'b0);          // 0
        send_word(8'h30, 1'b0);          // 0
        send_word(ChQuote, 1'b0);
    endtask

    // random string bodies, closed most of the time, cut off by the end mark otherwise
    task automatic test_random_strings(input int n_words);
        int first;
        first = words_sent;
        while (words_sent - first < n_words) begin
            repeat ($urandom_range(0, 6)) send_random_token();
            if ($urandom_range(0, 99) < 85) send_word(ChQuote, 1'b0);
            else send_word(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------

    // receiver stalls at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // every accepted result word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: word with none expected, data %h kind %0d last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                oldest = expected_words.pop_front();
                if (m_tdata !== oldest.data) begin
                    $display("%0t: data expected %h actual %h", $time, oldest.data, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== oldest.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, oldest.kind, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== oldest.last) begin
                    $display("%0t: last expected %b actual %b", $time, oldest.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb_json_string_unescape_utf8: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_idle_pct = 17;
        recv_idle_pct = 65;
        test_byte_extremes();
        test_bad_escapes();
        test_surrogate_pair();
        test_random_strings(130);

        // the other way round
        send_idle_pct = 65;
        recv_idle_pct = 17;
        test_random_strings(130);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(140);

        // drain, then wait on to catch stray words
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb_json_string_unescape_utf8: done, clean");
        end else begin
            $display("tb_json_string_unescape_utf8: done, errors");
        end
        $finish;
    end

endmodule
